/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PPCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define PPCF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ppcf_pkg.sv */
// Package: widths, defaults, state type and status struct of the change filter.
package ppcf_pkg;

    localparam int SLOT_COUNT_DEF    = 16;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam int ADDR_W     = 48;
    localparam int KIND_W     = 2;
    localparam int KEY_W      = ADDR_W + KIND_W;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int SLOT_NUM_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic finish;
        logic found;
        logic have_free;
    } lookup_status_t;

endpackage

/* sv/ppcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ppcf_lookup.sv */
// Slot scan: sequencer, occupancy bits, key compare and capture of the matching entry.
module ppcf_lookup #(
    parameter int SLOT_COUNT = ppcf_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_W    = ppcf_pkg::KEY_W + ppcf_pkg::LEN_W + 64,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start_accept,
    input  logic [ppcf_pkg::KEY_W-1:0]    key,
    output logic [IDX_W-1:0]              raddr,
    input  logic [ENTRY_W-1:0]            rdata,
    output ppcf_pkg::lookup_status_t      status,
    output logic [IDX_W-1:0]              slot_idx,
    output logic [ENTRY_W-1:0]            hit_entry
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    ppcf_pkg::state_t state_reg, state_next;

    logic [SLOT_COUNT-1:0] occupied_reg, occupied_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_active_reg, rd_active_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic                  have_free_reg, have_free_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [ENTRY_W-1:0]    hit_entry_reg, hit_entry_next;

    logic cmp_occ;
    logic hit_now;
    logic last_cmp;

    assign cmp_occ  = occupied_reg[cmp_idx_reg];
    assign hit_now  = cmp_valid_reg && cmp_occ
                      && (rdata[ENTRY_W-1 -: ppcf_pkg::KEY_W] == key);
    assign last_cmp = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppcf_pkg::ST_IDLE:
            begin
                if (start_accept)
                begin
                    state_next = ppcf_pkg::ST_SCAN;
                end
            end
            ppcf_pkg::ST_SCAN:
            begin
                if (hit_now || last_cmp)
                begin
                    state_next = ppcf_pkg::ST_FINISH;
                end
            end
            ppcf_pkg::ST_FINISH:
            begin
                state_next = ppcf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppcf_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan datapath
    always_comb
    begin
        occupied_next  = occupied_reg;
        rd_idx_next    = rd_idx_reg;
        rd_active_next = rd_active_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        have_free_next = have_free_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        hit_entry_next = hit_entry_reg;
        unique case (state_reg)
            ppcf_pkg::ST_IDLE:
            begin
                rd_idx_next    = '0;
                rd_active_next = 1'b1;
                cmp_valid_next = 1'b0;
                found_next     = 1'b0;
                have_free_next = 1'b0;
            end
            ppcf_pkg::ST_SCAN:
            begin
                // issue one read per cycle; its data is compared in the next cycle
                cmp_valid_next = rd_active_reg;
                cmp_idx_next   = rd_idx_reg;
                if (rd_idx_reg == LAST_IDX)
                begin
                    rd_active_next = 1'b0;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (hit_now)
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_entry_next = rdata;
                    rd_active_next = 1'b0;
                    cmp_valid_next = 1'b0;
                end
                else if (cmp_valid_reg && !cmp_occ && !have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_idx_next  = cmp_idx_reg;
                end
            end
            ppcf_pkg::ST_FINISH:
            begin
                // claim the free slot for an unknown peer
                if (!found_reg && have_free_reg)
                begin
                    occupied_next[free_idx_reg] = 1'b1;
                end
            end
            default:
            begin
                rd_active_next = 1'b0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        raddr            = rd_idx_reg;
        status.busy      = (state_reg != ppcf_pkg::ST_IDLE);
        status.finish    = (state_reg == ppcf_pkg::ST_FINISH);
        status.found     = found_reg;
        status.have_free = have_free_reg;
        slot_idx         = found_reg ? hit_idx_reg : free_idx_reg;
        hit_entry        = hit_entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppcf_pkg::ST_IDLE;
            occupied_reg  <= '0;
            rd_idx_reg    <= '0;
            rd_active_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            hit_idx_reg   <= '0;
            free_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occupied_reg  <= occupied_next;
            rd_idx_reg    <= rd_idx_next;
            rd_active_reg <= rd_active_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_reg     <= found_next;
            have_free_reg <= have_free_next;
            hit_idx_reg   <= hit_idx_next;
            free_idx_reg  <= free_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_entry_reg <= hit_entry_next;
    end

endmodule

/* sv/peer_payload_change_filter.sv */
// Top level: per-peer payload change filter over a slot table in RAM.
//
// Usage:
//   A report is transferred at a rising edge with start high and busy low; the
//   address, kind, length and payload ports are sampled there. busy stays high
//   while the slot table is scanned. Exactly one result per report appears on
//   changed, table_full, newly_added and slot_number, marked by done, which is
//   high for a single cycle. The receiver cannot hold results off; none is
//   ever stalled. The scan reads one slot per cycle from the table RAM's
//   single read port, whose read data is registered, and stops at the first
//   matching slot. busy falls in the cycle in which done is shown, so the next
//   report may be transferred at the edge that ends it; no new report is taken
//   before the last one's result is shown.
//   Reset clears every slot's occupied bit at once; the RAM contents are not
//   cleared, since no entry is matched before its slot is claimed. The table is
//   usable in the first cycle after reset.
module peer_payload_change_filter #(
    parameter int SLOT_COUNT    = ppcf_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BYTES = ppcf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ppcf_pkg::ADDR_W-1:0]       peer_address,
    input  logic [ppcf_pkg::KIND_W-1:0]       address_kind,
    input  logic [ppcf_pkg::LEN_W-1:0]        payload_length,
    input  logic [ppcf_pkg::DATA_W-1:0]       payload_bytes,
    output logic                              done,
    output logic                              changed,
    output logic                              table_full,
    output logic                              newly_added,
    output logic [ppcf_pkg::SLOT_NUM_W-1:0]   slot_number
);

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW      = PAYLOAD_BYTES * 8;
    localparam int LEN_W   = ppcf_pkg::LEN_W;
    localparam int KEY_W   = ppcf_pkg::KEY_W;
    localparam int ENTRY_W = KEY_W + LEN_W + PW;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES);

    ppcf_pkg::lookup_status_t status;

    logic                  start_accept;
    logic [KEY_W-1:0]      key_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [ppcf_pkg::DATA_W-1:0] data_reg;

    logic [IDX_W-1:0]      raddr;
    logic [ENTRY_W-1:0]    rdata;
    logic [IDX_W-1:0]      slot_idx;
    logic [ENTRY_W-1:0]    hit_entry;

    logic [ppcf_pkg::DATA_W-1:0] byte_mask;
    logic [PW-1:0]         new_data;
    logic [PW-1:0]         old_data;
    logic [LEN_W-1:0]      old_len;
    logic                  full;
    logic                  added;
    logic                  chg;
    logic                  we;
    logic [ENTRY_W-1:0]    wdata;
    logic [IDX_W+ppcf_pkg::SLOT_NUM_W-1:0] slot_ext;

    logic                  done_reg;
    logic                  changed_reg;
    logic                  table_full_reg;
    logic                  newly_added_reg;
    logic [ppcf_pkg::SLOT_NUM_W-1:0] slot_number_reg;

    assign start_accept = start && !status.busy;
    assign busy         = status.busy;

    // Capture the report; saturate the length to the payload size
    always_ff @(posedge clk)
    begin
        if (start_accept)
        begin
            key_reg  <= {address_kind, peer_address};
            len_reg  <= (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
            data_reg <= payload_bytes;
        end
    end

    ppcf_lookup #(
        .SLOT_COUNT (SLOT_COUNT),
        .ENTRY_W    (ENTRY_W)
    ) u_lookup (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_accept (start_accept),
        .key          (key_reg),
        .raddr        (raddr),
        .rdata        (rdata),
        .status       (status),
        .slot_idx     (slot_idx),
        .hit_entry    (hit_entry)
    );

    ppcf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (slot_idx),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        for (int b = 0; b < ppcf_pkg::DATA_W / 8; b++)
        begin
            byte_mask[b*8 +: 8] = (LEN_W'(b) < len_reg) ? 8'hFF : 8'h00;
        end
    end

    assign new_data = data_reg[PW-1:0] & byte_mask[PW-1:0];
    assign old_data = hit_entry[PW-1:0] & byte_mask[PW-1:0];
    assign old_len  = hit_entry[PW +: LEN_W];

    assign full  = !status.found && !status.have_free;
    assign added = !status.found && status.have_free;

    // A freshly claimed slot holds length zero
    assign chg = status.found ? ((len_reg != old_len) || (old_data != new_data))
                              : (full || (len_reg != '0));

    // Write back on a claim or a change; a claim with no change stores length zero
    assign we       = status.finish && !full && (added || chg);
    assign wdata    = {key_reg, len_reg, new_data};
    assign slot_ext = {{ppcf_pkg::SLOT_NUM_W{1'b0}}, slot_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= status.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.finish)
        begin
            changed_reg     <= chg;
            table_full_reg  <= full;
            newly_added_reg <= added;
            slot_number_reg <= full ? '0 : slot_ext[ppcf_pkg::SLOT_NUM_W-1:0];
        end
    end

    assign done        = done_reg;
    assign changed     = changed_reg;
    assign table_full  = table_full_reg;
    assign newly_added = newly_added_reg;
    assign slot_number = slot_number_reg;

endmodule

/* sv/ppcf_checker.sv */
// Port-level checker for the change filter, bound to the top level.
`include "assert_macros.svh"

module ppcf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              changed,
    input logic                              table_full,
    input logic                              newly_added,
    input logic [ppcf_pkg::SLOT_NUM_W-1:0]   slot_number
);

    `PPCF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "transfer did not raise busy")
    `PPCF_ASSERT_NXT(a_done_pulse, done, !done, "result shown for more than one cycle")
    `PPCF_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still scanning")
    `PPCF_ASSERT_NOW(a_full_result, done && table_full,
        changed && !newly_added && (slot_number == '0), "bad table-full result")

endmodule

bind peer_payload_change_filter ppcf_checker u_ppcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .changed     (changed),
    .table_full  (table_full),
    .newly_added (newly_added),
    .slot_number (slot_number)
);
